FILE: rtl/fpc_pkg.sv
package fpc_pkg;

	localparam int RULE_COUNT = 25;
	localparam int SET_COUNT = 10;
	localparam int IN_W = 16;
	localparam int SX_W = 30;
	localparam int N_W = 22;
	localparam int X_W = 28;
	localparam int M_W = 29;
	localparam int P_W = 57;
	localparam int MB_W = 17;
	localparam int RS2_W = 19;
	localparam int RSK_W = 21;
	localparam int SUM2_W = 21;
	localparam int SUMK_W = 24;
	localparam int DEN_W = 23;
	localparam int NUM_W = 40;
	localparam int Q_W = 17;
	localparam int F_W = 18;
	localparam int FORCE_SCALE = 430 * 256;
	localparam logic [MB_W-1:0] MEMB_ONE = MB_W'(65536);

	localparam logic [1:0] SH_LEFT = 2'd0;
	localparam logic [1:0] SH_RIGHT = 2'd1;
	localparam logic [1:0] SH_REG = 2'd2;

	localparam logic [1:0] RG_ZERO = 2'd0;
	localparam logic [1:0] RG_ONE = 2'd1;
	localparam logic [1:0] RG_SLOPE = 2'd2;

	localparam logic [2:0] DC_1600 = 3'd0;
	localparam logic [2:0] DC_1700 = 3'd1;
	localparam logic [2:0] DC_9600 = 3'd2;
	localparam logic [2:0] DC_9700 = 3'd3;
	localparam logic [2:0] DC_9800 = 3'd4;

	// floor(256*n/width) as floor((n << shift) * mul >> k), exact over the slope range
	localparam logic [M_W-1:0] DM_1600 = M_W'(((64'd1 << 26) + 64'd24) / 64'd25);
	localparam logic [M_W-1:0] DM_1700 = M_W'(((64'd1 << 34) + 64'd424) / 64'd425);
	localparam logic [M_W-1:0] DM_9600 = M_W'(((64'd1 << 30) + 64'd74) / 64'd75);
	localparam logic [M_W-1:0] DM_9700 = M_W'(((64'd1 << 40) + 64'd2424) / 64'd2425);
	localparam logic [M_W-1:0] DM_9800 = M_W'(((64'd1 << 38) + 64'd1224) / 64'd1225);

	// sets 0..4 fuzzify the angle signal, 5..9 the cart signal
	localparam logic [1:0] SET_SHAPE [SET_COUNT] = '{
		SH_LEFT, SH_REG, SH_REG, SH_REG, SH_RIGHT,
		SH_LEFT, SH_REG, SH_REG, SH_REG, SH_RIGHT};
	localparam int SET_A [SET_COUNT] = '{
		-3900, -3900, -1900, 200, 2200, -22900, -22900, -10900, 1300, 13100};
	localparam int SET_B [SET_COUNT] = '{
		-2300, -2300, -200, 1900, 3900, -13300, -13200, -1200, 10900, 22900};
	localparam int SET_C [SET_COUNT] = '{
		0, -1900, 200, 2200, 0, 0, -10900, 1200, 13200, 0};
	localparam int SET_D [SET_COUNT] = '{
		0, -200, 1900, 3900, 0, 0, -1200, 10900, 22900, 0};
	localparam logic [2:0] SET_CR [SET_COUNT] = '{
		DC_1600, DC_1600, DC_1700, DC_1700, DC_1700,
		DC_9600, DC_9700, DC_9700, DC_9600, DC_9800};
	localparam logic [2:0] SET_CF [SET_COUNT] = '{
		DC_1600, DC_1700, DC_1700, DC_1700, DC_1700,
		DC_9600, DC_9700, DC_9700, DC_9700, DC_9800};

	localparam int RULE_K [RULE_COUNT] = '{
		-1, 0, -2, 0, -3,
		0, -1, 0, -2, 0,
		1, 0, 0, 0, -1,
		0, 2, 0, 1, 0,
		3, 0, 2, 0, 1};

	typedef struct packed {
		logic signed [IN_W-1:0] angle;
		logic signed [IN_W-1:0] angle_rate;
		logic signed [IN_W-1:0] position;
		logic signed [IN_W-1:0] velocity;
	} sample_t;

	typedef struct packed {
		logic signed [F_W-1:0] force_res;
		logic no_rule_fired;
	} result_t;

	function automatic int dc_shift(input logic [2:0] cls);
		int s;
		case (cls)
			DC_1600: s = 2;
			DC_1700: s = 6;
			DC_9600: s = 1;
			DC_9700: s = 6;
			DC_9800: s = 5;
			default: s = 0;
		endcase
		return s;
	endfunction

	function automatic int dc_k(input logic [2:0] cls);
		int s;
		case (cls)
			DC_1600: s = 26;
			DC_1700: s = 34;
			DC_9600: s = 30;
			DC_9700: s = 40;
			DC_9800: s = 38;
			default: s = 0;
		endcase
		return s;
	endfunction

	function automatic logic [M_W-1:0] dc_mul(input logic [2:0] cls);
		logic [M_W-1:0] m;
		case (cls)
			DC_1600: m = DM_1600;
			DC_1700: m = DM_1700;
			DC_9600: m = DM_9600;
			DC_9700: m = DM_9700;
			DC_9800: m = DM_9800;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/fuzzy_pendulum_controller.sv
// fuzzy pendulum controller
// input channel sample (sample_valid / sample_ready) carries angle, angle rate,
// cart position and cart velocity; output channel result (result_valid /
// result_ready) carries the force with 8 fraction bits and the no-rule flag
// one result per sample, in order
// throughput: one sample per cycle unless stalled, set by the fully pipelined
// datapath: seven stages of fuzzification, rule weighting and summing, then a
// 17-stage restoring divider that retires one quotient bit per stage, then the
// output register
// reset clears every stage valid bit; the pipe comes up empty and ready
// when result_ready is low the stalled result holds; empty stages still fill,
// so sample_ready drops only once every stage holds an item
module fuzzy_pendulum_controller import fpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_ready,
	input sample_t sample,
	output logic result_valid,
	input logic result_ready,
	output result_t result
);

	localparam int DIV_BASE = 7;
	localparam int NSTG = DIV_BASE + Q_W + 1;

	logic [NSTG-1:0] v_q;
	logic [NSTG-1:0] en;

	logic signed [SX_W-1:0] s0x_s1, s1x_s1;
	logic [1:0] rg_s2 [SET_COUNT];
	logic [X_W-1:0] x_s2 [SET_COUNT];
	logic [2:0] cls_s2 [SET_COUNT];
	logic [1:0] rg_s3 [SET_COUNT];
	logic [P_W-1:0] p_s3 [SET_COUNT];
	logic [2:0] cls_s3 [SET_COUNT];
	logic [MB_W-1:0] mb_s4 [SET_COUNT];
	logic [RS2_W-1:0] rs2_s5 [5];
	logic signed [RSK_W-1:0] rsk_s5 [5];
	logic [SUM2_W-1:0] sum2_s6;
	logic signed [SUMK_W-1:0] sumk_s6;
	logic [NUM_W-1:0] num_s7;
	logic [DEN_W-1:0] den_s7;
	logic neg_s7, zero_s7;
	logic [NUM_W-1:0] dv_rem_s [Q_W];
	logic [Q_W-1:0] dv_quo_s [Q_W];
	logic [DEN_W-1:0] dv_den_s [Q_W];
	logic dv_neg_s [Q_W];
	logic dv_zero_s [Q_W];
	result_t res_s;

	// stall chain: a stage moves when it is empty or the next one moves
	always_comb begin
		en[NSTG-1] = ~v_q[NSTG-1] | result_ready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en[i] = ~v_q[i] | en[i+1];
		end
	end

	assign sample_ready = en[0];
	assign result_valid = v_q[NSTG-1];
	assign result = res_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= sample_valid;
			for (int i = 1; i < NSTG; i++) begin
				if (en[i])
					v_q[i] <= v_q[i-1];
			end
		end
	end

	// stage 1: combined signals scaled by 625
	logic signed [21:0] c0, c1;
	always_comb begin
		c0 = 22'(sample.angle) * 22'sd20 + 22'(sample.angle_rate) * 22'sd2;
		c1 = 22'(sample.position) * 22'sd6 + 22'(sample.velocity) * 22'sd9;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			s0x_s1 <= SX_W'(c0) * SX_W'(625);
			s1x_s1 <= SX_W'(c1) * SX_W'(625);
		end
	end

	// stage 2: trapezoid region and slope distance
	logic [1:0] rg_c [SET_COUNT];
	logic [X_W-1:0] x_c [SET_COUNT];
	logic [2:0] cls_c [SET_COUNT];
	always_comb begin
		for (int j = 0; j < SET_COUNT; j++) begin
			logic signed [SX_W-1:0] sx, ka, kb, kc, kd, n;
			sx = (j < 5) ? s0x_s1 : s1x_s1;
			ka = SX_W'(SET_A[j] * 256);
			kb = SX_W'(SET_B[j] * 256);
			kc = SX_W'(SET_C[j] * 256);
			kd = SX_W'(SET_D[j] * 256);
			n = '0;
			cls_c[j] = SET_CR[j];
			rg_c[j] = RG_SLOPE;
			case (SET_SHAPE[j])
				SH_LEFT: begin
					if (sx <= ka)
						rg_c[j] = RG_ONE;
					else if (sx >= kb)
						rg_c[j] = RG_ZERO;
					n = kb - sx;
				end
				SH_RIGHT: begin
					if (sx <= ka)
						rg_c[j] = RG_ZERO;
					else if (sx >= kb)
						rg_c[j] = RG_ONE;
					n = sx - ka;
				end
				default: begin
					if (sx <= ka || sx >= kd)
						rg_c[j] = RG_ZERO;
					else if (sx >= kb && sx <= kc)
						rg_c[j] = RG_ONE;
					if (sx < kb) begin
						n = sx - ka;
					end else begin
						n = kd - sx;
						cls_c[j] = SET_CF[j];
					end
				end
			endcase
			x_c[j] = X_W'(n[N_W-1:0]) << dc_shift(cls_c[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int j = 0; j < SET_COUNT; j++) begin
				rg_s2[j] <= rg_c[j];
				x_s2[j] <= x_c[j];
				cls_s2[j] <= cls_c[j];
			end
		end
	end

	// stage 3: reciprocal multiply
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < SET_COUNT; j++) begin
				rg_s3[j] <= rg_s2[j];
				cls_s3[j] <= cls_s2[j];
				p_s3[j] <= P_W'(x_s2[j]) * P_W'(dc_mul(cls_s2[j]));
			end
		end
	end

	// stage 4: memberships
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int j = 0; j < SET_COUNT; j++) begin
				case (rg_s3[j])
					RG_ONE: mb_s4[j] <= MEMB_ONE;
					RG_SLOPE: mb_s4[j] <= MB_W'(p_s3[j] >> dc_k(cls_s3[j]));
					default: mb_s4[j] <= '0;
				endcase
			end
		end
	end

	// stage 5: rule weights, row sums
	logic [RS2_W-1:0] rs2_c [5];
	logic signed [RSK_W-1:0] rsk_c [5];
	always_comb begin
		for (int r = 0; r < 5; r++) begin
			rs2_c[r] = '0;
			rsk_c[r] = '0;
			for (int c = 0; c < 5; c++) begin
				logic [MB_W-1:0] w;
				w = (mb_s4[r] < mb_s4[9-c]) ? mb_s4[r] : mb_s4[9-c];
				rs2_c[r] = rs2_c[r] + RS2_W'(w);
				rsk_c[r] = rsk_c[r] + RSK_W'(signed'({1'b0, w}) * RULE_K[r*5+c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int r = 0; r < 5; r++) begin
				rs2_s5[r] <= rs2_c[r];
				rsk_s5[r] <= rsk_c[r];
			end
		end
	end

	// stage 6: totals
	logic [SUM2_W-1:0] sum2_c;
	logic signed [SUMK_W-1:0] sumk_c;
	always_comb begin
		sum2_c = '0;
		sumk_c = '0;
		for (int r = 0; r < 5; r++) begin
			sum2_c = sum2_c + SUM2_W'(rs2_s5[r]);
			sumk_c = sumk_c + SUMK_W'(rsk_s5[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			sum2_s6 <= sum2_c;
			sumk_s6 <= sumk_c;
		end
	end

	// stage 7: dividend with half-divisor rounding
	logic [DEN_W-1:0] mag_c, den_c;
	logic signed [SUMK_W-1:0] abs_c;
	always_comb begin
		abs_c = (sumk_s6 < 0) ? -sumk_s6 : sumk_s6;
		mag_c = DEN_W'(abs_c);
		den_c = DEN_W'(sum2_s6) * DEN_W'(3);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			num_s7 <= NUM_W'(mag_c) * NUM_W'(FORCE_SCALE) + NUM_W'(den_c >> 1);
			den_s7 <= den_c;
			neg_s7 <= sumk_s6 < 0;
			zero_s7 <= sum2_s6 == '0;
		end
	end

	// restoring divider, one quotient bit per stage, msb first
	logic [NUM_W-1:0] dv_rem_c [Q_W];
	logic [Q_W-1:0] dv_quo_c [Q_W];
	always_comb begin
		for (int i = 0; i < Q_W; i++) begin
			logic [NUM_W-1:0] rin, t;
			logic [Q_W-1:0] qin;
			logic [DEN_W-1:0] din;
			if (i == 0) begin
				rin = num_s7;
				qin = '0;
				din = den_s7;
			end else begin
				rin = dv_rem_s[i-1];
				qin = dv_quo_s[i-1];
				din = dv_den_s[i-1];
			end
			t = NUM_W'(din) << (Q_W - 1 - i);
			if (rin >= t) begin
				dv_rem_c[i] = rin - t;
				dv_quo_c[i] = qin | (Q_W'(1) << (Q_W - 1 - i));
			end else begin
				dv_rem_c[i] = rin;
				dv_quo_c[i] = qin;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < Q_W; i++) begin
			if (en[DIV_BASE+i]) begin
				dv_rem_s[i] <= dv_rem_c[i];
				dv_quo_s[i] <= dv_quo_c[i];
				if (i == 0) begin
					dv_den_s[i] <= den_s7;
					dv_neg_s[i] <= neg_s7;
					dv_zero_s[i] <= zero_s7;
				end else begin
					dv_den_s[i] <= dv_den_s[i-1];
					dv_neg_s[i] <= dv_neg_s[i-1];
					dv_zero_s[i] <= dv_zero_s[i-1];
				end
			end
		end
	end

	// output register
	logic signed [F_W-1:0] qs_c;
	always_comb begin
		qs_c = signed'(F_W'(dv_quo_s[Q_W-1]));
	end

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			res_s.no_rule_fired <= dv_zero_s[Q_W-1];
			if (dv_zero_s[Q_W-1])
				res_s.force_res <= '0;
			else if (dv_neg_s[Q_W-1])
				res_s.force_res <= -qs_c;
			else
				res_s.force_res <= qs_c;
		end
	end

endmodule

FILE: rtl/fpc_checker.sv
module fpc_checker import fpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_ready,
	input sample_t sample,
	input logic result_valid,
	input logic result_ready,
	input result_t result
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// a free output never blocks the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> sample_ready)
		else $error("input blocked while output free");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.no_rule_fired |-> result.force_res == '0)
		else $error("force nonzero with no rule fired");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.force_res <= F_W'(FORCE_SCALE)
			&& result.force_res >= -F_W'(FORCE_SCALE))
		else $error("force out of range");

endmodule

bind fuzzy_pendulum_controller fpc_checker u_fpc_checker (.*);
